// ----- design/ffdm_pkg.sv -----
package ffdm_pkg;

  localparam int VOLUME_BITS   = 32;
  localparam int FRACTION_BITS = 16;
  localparam int FRAC_W        = FRACTION_BITS + 1;
  localparam int PROD_BITS     = VOLUME_BITS + FRAC_W;
  localparam int SUM_BITS      = 64;
  localparam int OUT_FRAC      = 16;
  localparam int OUT_BITS      = 32;
  localparam int DVD_BITS      = SUM_BITS + OUT_FRAC;
  localparam int DIV_STEPS     = DVD_BITS;
  localparam int CNT_BITS      = $clog2(DIV_STEPS);

  localparam logic [OUT_BITS-1:0] POS_LIMIT = {1'b0, {(OUT_BITS-1){1'b1}}};
  localparam logic [OUT_BITS-1:0] NEG_LIMIT = {1'b1, {(OUT_BITS-1){1'b0}}};

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL0 = 9'b000000010,
    S_MUL1 = 9'b000000100,
    S_MUL2 = 9'b000001000,
    S_ACC  = 9'b000010000,
    S_PREP = 9'b000100000,
    S_DIV  = 9'b001000000,
    S_FIN  = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

// ----- design/fraction_field_drift_metrics_unit.sv -----
// Cell item: 3 passes through one shared multiplier (S_MUL0 to S_MUL2), then the last sum
// update (S_ACC); cell_stall is high while the sequencer is not idle, so a cell is taken
// only once the last is through. Last cell: two 80-step restoring divisions (one quotient
// bit per cycle) on a shared 65-bit subtractor, then result_valid is set from S_OUT; a zero
// start sum skips the divisions. Cells are taken while the result waits in its register.
// Reset (rst, synchronous): sums cleared, sequencer idle, no result pending.
module fraction_field_drift_metrics_unit
  import ffdm_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cell_valid,
  output logic                       cell_stall,
  input  logic [VOLUME_BITS-1:0]     cell_volume,
  input  logic [FRAC_W-1:0]          fraction_start,
  input  logic [FRAC_W-1:0]          fraction_now,
  input  logic                       last_cell,
  output logic                       result_valid,
  input  logic                       result_stall,
  output logic [OUT_BITS-1:0]        shape_error,
  output logic signed [OUT_BITS-1:0] volume_change,
  output logic                       zero_reference
);

  state_t state;

  logic [VOLUME_BITS-1:0] vol;
  logic [FRAC_W-1:0]      a0;
  logic [FRAC_W-1:0]      a1;
  logic [FRAC_W-1:0]      diff;
  logic                   last;
  logic [PROD_BITS-1:0]   prod;
  logic [FRAC_W-1:0]      mul_b;
  logic [SUM_BITS-1:0]    prod_ext;

  logic [SUM_BITS-1:0]    change_sum;
  logic [SUM_BITS-1:0]    start_sum;
  logic [SUM_BITS-1:0]    now_sum;

  // divider
  logic [DVD_BITS-1:0]    dvd;
  logic [SUM_BITS-1:0]    rem;
  logic [OUT_BITS:0]      quo;
  logic                   quo_ovf;
  logic [CNT_BITS-1:0]    div_count;
  logic                   div_sel;
  logic [SUM_BITS:0]      rem_sh;
  logic [SUM_BITS:0]      rem_sub;
  logic                   rem_ge;
  logic                   load_div;
  logic [SUM_BITS-1:0]    div_num;
  logic                   now_below;
  logic                   quo_big;

  logic [OUT_BITS-1:0]    res_shape;
  logic [OUT_BITS-1:0]    res_change;
  logic [OUT_BITS-1:0]    res_change_next;
  logic [OUT_BITS-1:0]    neg_mag;
  logic                   res_zero;
  logic                   out_load;
  logic                   cell_take;

  function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                  input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
  endfunction

  assign cell_stall = (state != S_IDLE);
  assign cell_take  = cell_valid && !cell_stall;

  always_comb begin
    case (state)
      S_MUL0:  mul_b = a0;
      S_MUL1:  mul_b = a1;
      default: mul_b = diff;
    endcase
  end

  assign prod_ext = {{(SUM_BITS-PROD_BITS){1'b0}}, prod};

  // one restoring step: shift in next dividend bit, trial subtract
  assign rem_sh  = {rem, dvd[DVD_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, start_sum};
  assign rem_ge  = !rem_sub[SUM_BITS];

  assign now_below = (now_sum < start_sum);
  assign quo_big   = quo_ovf || quo[OUT_BITS];
  assign load_div  = ((state == S_PREP) && (start_sum != '0)) ||
                     ((state == S_FIN) && !div_sel);
  always_comb begin
    if (state == S_PREP) begin
      div_num = change_sum;
    end else if (now_below) begin
      div_num = start_sum - now_sum;
    end else begin
      div_num = now_sum - start_sum;
    end
  end

  always_comb begin
    neg_mag = (quo_big || (quo[OUT_BITS-1] && (quo[OUT_BITS-2:0] != '0))) ?
              NEG_LIMIT : quo[OUT_BITS-1:0];
    if (now_below) begin
      res_change_next = '0 - neg_mag;
    end else if (quo_big || quo[OUT_BITS-1]) begin
      res_change_next = POS_LIMIT;
    end else begin
      res_change_next = quo[OUT_BITS-1:0];
    end
  end

  assign out_load = (state == S_OUT) && !(result_valid && result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      change_sum   <= '0;
      start_sum    <= '0;
      now_sum      <= '0;
      result_valid <= 1'b0;
      div_sel      <= 1'b0;
      div_count    <= '0;
    end else begin
      if (out_load) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (cell_take) begin
            state <= S_MUL0;
          end
        end
        S_MUL0: state <= S_MUL1;
        S_MUL1: begin
          start_sum <= sat_add(start_sum, prod_ext);
          state     <= S_MUL2;
        end
        S_MUL2: begin
          now_sum <= sat_add(now_sum, prod_ext);
          state   <= S_ACC;
        end
        S_ACC: begin
          change_sum <= sat_add(change_sum, prod_ext);
          state      <= last ? S_PREP : S_IDLE;
        end
        S_PREP: begin
          div_sel   <= 1'b0;
          div_count <= CNT_BITS'(DIV_STEPS - 1);
          state     <= (start_sum == '0) ? S_OUT : S_DIV;
        end
        S_DIV: begin
          div_count <= div_count - 1'b1;
          if (div_count == '0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (!div_sel) begin
            div_sel   <= 1'b1;
            div_count <= CNT_BITS'(DIV_STEPS - 1);
            state     <= S_DIV;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            change_sum <= '0;
            start_sum  <= '0;
            now_sum    <= '0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (cell_take) begin
      vol  <= cell_volume;
      a0   <= fraction_start;
      a1   <= fraction_now;
      diff <= (fraction_now >= fraction_start) ? (fraction_now - fraction_start)
                                               : (fraction_start - fraction_now);
      last <= last_cell;
    end

    if ((state == S_MUL0) || (state == S_MUL1) || (state == S_MUL2)) begin
      prod <= PROD_BITS'(vol) * PROD_BITS'(mul_b);
    end

    if (load_div) begin
      dvd     <= {div_num, {OUT_FRAC{1'b0}}};
      rem     <= '0;
      quo     <= '0;
      quo_ovf <= 1'b0;
    end else if (state == S_DIV) begin
      dvd     <= {dvd[DVD_BITS-2:0], 1'b0};
      rem     <= rem_ge ? rem_sub[SUM_BITS-1:0] : rem_sh[SUM_BITS-1:0];
      quo     <= {quo[OUT_BITS-1:0], rem_ge};
      quo_ovf <= quo_ovf || quo[OUT_BITS];
    end

    if (state == S_PREP) begin
      res_shape  <= '0;
      res_change <= '0;
      res_zero   <= (start_sum == '0);
    end else if (state == S_FIN) begin
      if (!div_sel) begin
        res_shape <= quo_big ? {OUT_BITS{1'b1}} : quo[OUT_BITS-1:0];
      end else begin
        res_change <= res_change_next;
      end
    end

    if (out_load) begin
      shape_error    <= res_shape;
      volume_change  <= res_change;
      zero_reference <= res_zero;
    end
  end

  a_rise_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == S_OUT))
    else $error("result_valid rose outside the output step");

  a_zero_ref: assert property (@(posedge clk) disable iff (rst)
    (result_valid && zero_reference) |-> (shape_error == '0 && volume_change == '0))
    else $error("zero start sum gave nonzero ratios");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (change_sum == '0 && start_sum == '0 && now_sum == '0))
    else $error("sums not cleared after result");

  a_div_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (start_sum != '0))
    else $error("division started with zero divisor");

  a_div_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (div_count <= CNT_BITS'(DIV_STEPS - 1)))
    else $error("division step count out of range");

endmodule

// ----- tb/tb_fraction_field_drift_metrics_unit.sv -----
`timescale 1ns / 1ps

module tb_fraction_field_drift_metrics_unit;
  import ffdm_pkg::*;

  localparam int QUIET_LIMIT = 5000;   // cycles with no transfer on either side
  localparam int END_SETTLE  = 200;    // longer than the division latency
  localparam int HOLD_CYCLES = 700;

  localparam logic [VOLUME_BITS-1:0] VOL_MAX  = '1;
  localparam logic [FRAC_W-1:0]      FRAC_MAX = '1;
  localparam logic [FRAC_W-1:0]      FRAC_ONE = FRAC_W'(1 << FRACTION_BITS);

  localparam logic [SUM_BITS-1:0] SHAPE_LIMIT = {{(SUM_BITS-OUT_BITS){1'b0}}, {OUT_BITS{1'b1}}};
  localparam logic [SUM_BITS-1:0] GROW_LIMIT  = SUM_BITS'(POS_LIMIT);
  localparam logic [SUM_BITS-1:0] SHRINK_LIMIT = SUM_BITS'(NEG_LIMIT);

  typedef enum {MESH_MIXED, MESH_DRIFT, MESH_ZERO_START, MESH_SPARSE_START} mesh_style_t;

  typedef struct {
    logic [OUT_BITS-1:0]        shape;
    logic signed [OUT_BITS-1:0] vchange;
    logic                       zref;
  } drift_metrics_t;

  logic                       clk;
  logic                       rst;
  logic                       cell_valid;
  logic                       cell_stall;
  logic [VOLUME_BITS-1:0]     cell_volume;
  logic [FRAC_W-1:0]          fraction_start;
  logic [FRAC_W-1:0]          fraction_now;
  logic                       last_cell;
  logic                       result_valid;
  logic                       result_stall;
  logic [OUT_BITS-1:0]        shape_error;
  logic signed [OUT_BITS-1:0] volume_change;
  logic                       zero_reference;

  // running mesh sums, mirrored from the accepted cells
  logic [SUM_BITS-1:0] change_acc = '0;
  logic [SUM_BITS-1:0] start_acc  = '0;
  logic [SUM_BITS-1:0] now_acc    = '0;

  drift_metrics_t pending_metrics[$];
  int mismatch_count = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;

  fraction_field_drift_metrics_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cell_valid     (cell_valid),
    .cell_stall     (cell_stall),
    .cell_volume    (cell_volume),
    .fraction_start (fraction_start),
    .fraction_now   (fraction_now),
    .last_cell      (last_cell),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .shape_error    (shape_error),
    .volume_change  (volume_change),
    .zero_reference (zero_reference)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [SUM_BITS-1:0] add_saturating(input logic [SUM_BITS-1:0] a,
                                                         input logic [SUM_BITS-1:0] b);
    logic [SUM_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
  endfunction

  // floor(num * 2^OUT_FRAC / den), clipped to limit
  function automatic logic [SUM_BITS-1:0] q16_quotient(input logic [SUM_BITS-1:0] num,
                                                       input logic [SUM_BITS-1:0] den,
                                                       input logic [SUM_BITS-1:0] limit);
    logic [SUM_BITS+OUT_FRAC-1:0] q;
    q = {num, {OUT_FRAC{1'b0}}} / {{OUT_FRAC{1'b0}}, den};
    return (q > {{OUT_FRAC{1'b0}}, limit}) ? limit : q[SUM_BITS-1:0];
  endfunction

  function automatic void accumulate_cell(input logic [VOLUME_BITS-1:0] vol,
                                          input logic [FRAC_W-1:0] a0,
                                          input logic [FRAC_W-1:0] a1,
                                          input logic last);
    logic [FRAC_W-1:0]   diff;
    logic [SUM_BITS-1:0] mag;
    drift_metrics_t      want;
    diff = (a1 >= a0) ? a1 - a0 : a0 - a1;
    change_acc = add_saturating(change_acc, SUM_BITS'(vol) * SUM_BITS'(diff));
    start_acc  = add_saturating(start_acc, SUM_BITS'(vol) * SUM_BITS'(a0));
    now_acc    = add_saturating(now_acc, SUM_BITS'(vol) * SUM_BITS'(a1));
    if (last) begin
      if (start_acc == '0) begin
        want.shape   = '0;
        want.vchange = '0;
        want.zref    = 1'b1;
      end else begin
        want.zref  = 1'b0;
        want.shape = OUT_BITS'(q16_quotient(change_acc, start_acc, SHAPE_LIMIT));
        if (now_acc >= start_acc) begin
          want.vchange = OUT_BITS'(q16_quotient(now_acc - start_acc, start_acc, GROW_LIMIT));
        end else begin
          mag = q16_quotient(start_acc - now_acc, start_acc, SHRINK_LIMIT);
          want.vchange = -OUT_BITS'(mag);
        end
      end
      pending_metrics.push_back(want);
      change_acc = '0;
      start_acc  = '0;
      now_acc    = '0;
    end
  endfunction

  // Offers one cell, waits for its transfer, leaves valid high on return.
  task automatic send_cell(input logic [VOLUME_BITS-1:0] vol, input logic [FRAC_W-1:0] a0,
                           input logic [FRAC_W-1:0] a1, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      cell_valid <= 1'b0;
      @(posedge clk);
    end
    cell_valid     <= 1'b1;
    cell_volume    <= vol;
    fraction_start <= a0;
    fraction_now   <= a1;
    last_cell      <= last;
    @(posedge clk);
    while (cell_stall) @(posedge clk);
    accumulate_cell(vol, a0, a1, last);
  endtask

  task automatic drain_results();
    cell_valid <= 1'b0;
    while (pending_metrics.size() != 0) @(posedge clk);
  endtask

  function automatic logic [VOLUME_BITS-1:0] pick_volume();
    case ($urandom_range(9))
      0:       return '0;
      1:       return VOL_MAX;
      2, 3:    return VOLUME_BITS'($urandom_range(0, 255));
      default: return VOLUME_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [FRAC_W-1:0] pick_fraction();
    case ($urandom_range(7))
      0:       return '0;
      1:       return FRAC_MAX;
      2:       return FRAC_ONE;
      3, 4:    return FRAC_W'($urandom_range(0, FRAC_ONE));
      default: return FRAC_W'($urandom_range(0, FRAC_MAX));
    endcase
  endfunction

  task automatic send_mesh(input int n_cells, input mesh_style_t style);
    logic [FRAC_W-1:0] a0;
    logic [FRAC_W-1:0] a1;
    int                t;
    for (int i = 0; i < n_cells; i++) begin
      case (style)
        MESH_DRIFT: begin
          a0 = FRAC_W'($urandom_range(0, FRAC_ONE));
          t  = int'(a0) + int'($urandom_range(0, 2000)) - 1000;
          a1 = (t < 0) ? '0 : FRAC_W'(t);
        end
        MESH_ZERO_START: begin
          a0 = '0;
          a1 = pick_fraction();
        end
        MESH_SPARSE_START: begin
          a0 = FRAC_W'($urandom_range(0, 3));
          a1 = pick_fraction();
        end
        default: begin
          a0 = pick_fraction();
          a1 = pick_fraction();
        end
      endcase
      send_cell(pick_volume(), a0, a1, i == n_cells - 1);
    end
  endtask

  task automatic test_zero_reference();
    send_cell('0, FRAC_MAX, 17'd5, 1'b1);
    send_cell(VOL_MAX, '0, FRAC_MAX, 1'b0);
    send_cell(VOLUME_BITS'(12345), '0, 17'd1, 1'b1);
    send_cell('0, '0, '0, 1'b1);
  endtask

  task automatic test_field_extremes();
    send_cell(VOL_MAX, FRAC_MAX, '0, 1'b1);          // shrinks to -1.0
    send_cell(VOL_MAX, FRAC_MAX, FRAC_MAX, 1'b1);
    send_cell(VOLUME_BITS'(1), 17'd1, FRAC_MAX, 1'b1); // both ratios clip
    send_cell(VOL_MAX, FRAC_ONE, FRAC_ONE, 1'b1);
    send_cell(VOL_MAX, 17'd1, '0, 1'b1);
    send_cell(VOLUME_BITS'(1), '0, '0, 1'b0);
    send_cell(VOLUME_BITS'(1), FRAC_MAX, FRAC_MAX - 17'd1, 1'b1);
    send_cell(VOLUME_BITS'(1000), FRAC_ONE + 17'd1, FRAC_MAX, 1'b1); // above 1.0
    send_cell(VOL_MAX, FRAC_ONE, FRAC_ONE + 17'd1, 1'b0);
    send_cell(32'h5555_5555, 17'h0AAAA, 17'h15555, 1'b0);
    send_cell(32'hAAAA_AAAA, 17'h15555, 17'h0AAAA, 1'b1);
  endtask

  // Full-scale cells push the start and change sums past 2^53.
  task automatic test_large_sums();
    for (int i = 0; i < 20; i++) send_cell(VOL_MAX, FRAC_MAX, '0, 1'b0);
    for (int i = 0; i < 10; i++) send_cell(pick_volume(), FRAC_MAX, pick_fraction(), i == 9);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_request   = HOLD_CYCLES;
    for (int m = 0; m < 4; m++) send_mesh(2, MESH_MIXED);
    drain_results();
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_cells);
    int          sent;
    int          len;
    mesh_style_t style;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_cells) begin
      len = ($urandom_range(9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 24);
      case ($urandom_range(19))
        0:             style = MESH_ZERO_START;
        1, 2:          style = MESH_SPARSE_START;
        3, 4, 5, 6, 7: style = MESH_DRIFT;
        default:       style = MESH_MIXED;
      endcase
      send_mesh(len, style);
      sent += len;
    end
  endtask

  // result side: check each transfer, then pick the next stall value
  initial begin
    drift_metrics_t want;
    int             hold_left;
    result_stall = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_metrics.size() == 0) begin
          $display("%0t: result with none expected: shape_error %h volume_change %h zero %b",
                   $time, shape_error, volume_change, zero_reference);
          mismatch_count++;
        end else begin
          want = pending_metrics.pop_front();
          if (shape_error !== want.shape) begin
            $display("%0t: shape_error expected %h actual %h", $time, want.shape, shape_error);
            mismatch_count++;
          end
          if (volume_change !== want.vchange) begin
            $display("%0t: volume_change expected %h actual %h",
                     $time, want.vchange, volume_change);
            mismatch_count++;
          end
          if (zero_reference !== want.zref) begin
            $display("%0t: zero_reference expected %b actual %b",
                     $time, want.zref, zero_reference);
            mismatch_count++;
          end
        end
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cell_valid && !cell_stall) || (result_valid && !result_stall)) quiet = 0;
      else quiet++;
    end
    $display("%0t: timeout, no transfer for %0d cycles", $time, QUIET_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst            = 1'b1;
    cell_valid     = 1'b0;
    cell_volume    = '0;
    fraction_start = '0;
    fraction_now   = '0;
    last_cell      = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_zero_reference();
    test_field_extremes();
    test_large_sums();
    test_output_backpressure();
    test_random_traffic(0, 0, 445);
    test_random_traffic(69, 0, 445);
    test_random_traffic(0, 69, 445);
    test_random_traffic(37, 37, 445);

    drain_results();
    repeat (END_SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
